[sv/btc_pkg.sv]
package btc_pkg;

  localparam int NUM_SETS = 4096;
  localparam int NUM_WAYS = 4;

  localparam int ADDR_W = 64;
  localparam int VAL_W  = 64;

  localparam int SET_W = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
  localparam int WAY_W = $clog2(NUM_WAYS);

  // address bit positions of the set index and of the victim way
  localparam int SET_LSB    = 2;
  localparam int VICTIM_LSB = 4;

  localparam logic [SET_W-1:0] SET_MASK = SET_W'(NUM_SETS - 1);
  localparam logic [WAY_W-1:0] WAY_MASK = WAY_W'(NUM_WAYS - 1);

  localparam logic [1:0] MODE_LOOKUP = 2'd0;
  localparam logic [1:0] MODE_INSERT = 2'd1;
  localparam logic [1:0] MODE_CLEAR  = 2'd2;

  localparam logic [1:0] KIND_NONE   = 2'd0;
  localparam logic [1:0] KIND_UPDATE = 2'd1;
  localparam logic [1:0] KIND_FILL   = 2'd2;
  localparam logic [1:0] KIND_EVICT  = 2'd3;

  typedef struct packed {
    logic [1:0]        mode;
    logic [ADDR_W-1:0] block_addr;
    logic [VAL_W-1:0]  code_value;
  } btc_in_t;

  typedef struct packed {
    logic             hit;
    logic [VAL_W-1:0] code_out;
    logic [1:0]       way_index;
    logic [1:0]       insert_kind;
  } btc_out_t;

  // one set: all tags and all values side by side
  typedef struct packed {
    logic [NUM_WAYS-1:0][ADDR_W-1:0] tags;
    logic [NUM_WAYS-1:0][VAL_W-1:0]  vals;
  } btc_row_t;

  localparam int ROW_W = $bits(btc_row_t);

  function automatic logic [SET_W-1:0] set_of(input logic [ADDR_W-1:0] addr);
    return addr[SET_LSB +: SET_W] & SET_MASK;
  endfunction

endpackage

[sv/block_translation_cache_unit.sv]
// Four-way set-associative translation cache from a 64-bit guest address to a
// 64-bit host code value, zero meaning empty. Each set lives in one row of a
// single-port-read, single-port-write memory (all tags and values of the set
// side by side). A word's set row is read in the cycle the word is accepted;
// in ST_LOOK the ways are then compared and, once the output is free, the
// result is registered and, for an insert, the modified row written back.
// in_stall is high outside ST_IDLE, so a new word is not taken before the
// last one is through. A clear word sweeps the memory one set per cycle,
// then registers its all-zero result in ST_DONE. After reset the same sweep
// runs once with in_stall high before the first word is taken.
// A result waiting on out_stall holds the block in its final step.
module block_translation_cache_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  btc_pkg::btc_in_t   in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output btc_pkg::btc_out_t  out_data
);
  import btc_pkg::*;

  localparam logic [2:0] ST_INIT = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_LOOK = 3'd2;
  localparam logic [2:0] ST_CLR  = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  logic [2:0]       state_r, state_nxt;
  logic [SET_W-1:0] cnt_r, cnt_nxt;
  btc_in_t          item_r;
  logic             out_valid_r;
  btc_out_t         out_data_r;

  logic             accept;
  logic             out_free;
  logic             load;
  btc_out_t         load_data;

  logic             ram_we;
  logic [SET_W-1:0] ram_waddr;
  logic [ROW_W-1:0] ram_wdata;
  logic [ROW_W-1:0] ram_rdata;
  btc_row_t         rd_row;

  btc_out_t         sel_res;
  btc_row_t         sel_row;
  logic             sel_we;

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign rd_row   = ram_rdata;

  btc_ram #(
    .DEPTH (NUM_SETS),
    .WIDTH (ROW_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (set_of(in_data.block_addr)),
    .rdata (ram_rdata)
  );

  btc_way_sel u_sel (
    .item    (item_r),
    .row     (rd_row),
    .res     (sel_res),
    .row_nxt (sel_row),
    .wr_en   (sel_we)
  );

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    ram_we    = 1'b0;
    ram_waddr = set_of(item_r.block_addr);
    ram_wdata = sel_row;
    load      = 1'b0;
    load_data = sel_res;
    case (state_r)
      ST_INIT, ST_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_r;
        ram_wdata = '0;
        if (cnt_r == SET_MASK) begin
          cnt_nxt   = '0;
          state_nxt = (state_r == ST_INIT) ? ST_IDLE : ST_DONE;
        end else begin
          cnt_nxt = cnt_r + SET_W'(1);
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_nxt = (in_data.mode == MODE_CLEAR) ? ST_CLR : ST_LOOK;
        end
      end
      ST_LOOK: begin
        if (out_free) begin
          load      = 1'b1;
          ram_we    = sel_we;
          state_nxt = ST_IDLE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          load      = 1'b1;
          load_data = '0;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_INIT;
        cnt_nxt   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_data;
    end
    if (load) begin
      out_data_r <= load_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[sv/btc_ram.sv]
module btc_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[sv/btc_way_sel.sv]
module btc_way_sel (
  input  btc_pkg::btc_in_t  item,
  input  btc_pkg::btc_row_t row,
  output btc_pkg::btc_out_t res,
  output btc_pkg::btc_row_t row_nxt,
  output logic              wr_en
);
  import btc_pkg::*;

  logic [NUM_WAYS-1:0] tag_eq;
  logic [NUM_WAYS-1:0] live;
  logic                hit_any;
  logic                tag_any;
  logic                empty_any;
  logic [WAY_W-1:0]    hit_w;
  logic [WAY_W-1:0]    tag_w;
  logic [WAY_W-1:0]    empty_w;
  logic [WAY_W-1:0]    victim;

  always_comb begin
    for (int w = 0; w < NUM_WAYS; w++) begin
      tag_eq[w] = (row.tags[w] == item.block_addr);
      live[w]   = (row.vals[w] != '0);
    end
  end

  // lowest way wins
  always_comb begin
    hit_any   = 1'b0;
    tag_any   = 1'b0;
    empty_any = 1'b0;
    hit_w     = '0;
    tag_w     = '0;
    empty_w   = '0;
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      if (tag_eq[w] && live[w]) begin
        hit_any = 1'b1;
        hit_w   = WAY_W'(w);
      end
      if (tag_eq[w]) begin
        tag_any = 1'b1;
        tag_w   = WAY_W'(w);
      end
      if (!live[w]) begin
        empty_any = 1'b1;
        empty_w   = WAY_W'(w);
      end
    end
  end

  assign victim = item.block_addr[VICTIM_LSB +: WAY_W] & WAY_MASK;

  always_comb begin
    res     = '0;
    row_nxt = row;
    wr_en   = 1'b0;
    case (item.mode)
      MODE_LOOKUP: begin
        if (hit_any) begin
          res.hit       = 1'b1;
          res.code_out  = row.vals[hit_w];
          res.way_index = 2'(hit_w);
        end
      end
      MODE_INSERT: begin
        wr_en = 1'b1;
        if (tag_any) begin
          row_nxt.vals[tag_w] = item.code_value;
          res.way_index       = 2'(tag_w);
          res.insert_kind     = KIND_UPDATE;
        end else if (empty_any) begin
          row_nxt.tags[empty_w] = item.block_addr;
          row_nxt.vals[empty_w] = item.code_value;
          res.way_index         = 2'(empty_w);
          res.insert_kind       = KIND_FILL;
        end else begin
          row_nxt.tags[victim] = item.block_addr;
          row_nxt.vals[victim] = item.code_value;
          res.way_index        = 2'(victim);
          res.insert_kind      = KIND_EVICT;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

[sv/btc_checker.sv]
module btc_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input btc_pkg::btc_out_t out_data
);
  import btc_pkg::*;

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result word changed");

  // one word in flight: accepted word stalls the next cycle
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken in back to back cycles");

  a_hit_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.hit |-> out_data.insert_kind == KIND_NONE &&
      out_data.code_out != '0)
    else $error("hit with insert kind or empty value");

  a_miss_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.hit |-> out_data.code_out == '0)
    else $error("code value without hit");

endmodule

bind block_translation_cache_unit btc_checker u_btc_checker (.*);

[bench/block_translation_cache_unit_tb.sv]
module block_translation_cache_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import btc_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int TOTAL_WAYS = NUM_SETS * NUM_WAYS;
  localparam int PHASES = 4;
  localparam int WORDS_PER_PHASE = 450;
  localparam logic [63:0] ALL_ONES = '1;
  localparam logic [63:0] SET5_BASE = 64'h14;

  typedef struct packed {
    btc_in_t  word;
    logic     fixed;
    btc_out_t result;
  } stim_row_t;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  btc_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  btc_out_t out_data;

  logic [63:0] shadow_tags [0:TOTAL_WAYS-1];
  logic [63:0] shadow_vals [0:TOTAL_WAYS-1];
  btc_out_t    cache_replies_q [$];
  stim_row_t   directed_rows [$];
  logic [63:0] addr_pool [$];
  int          mismatch_count = 0;
  int unsigned stall_cycle = 0;
  btc_out_t    reply_want;

  block_translation_cache_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #5ns clk = ~clk;

  function automatic void wipe_shadow();
    for (int e = 0; e < TOTAL_WAYS; e++) begin
      shadow_tags[e] = '0;
      shadow_vals[e] = '0;
    end
  endfunction

  // shadow copy of the cache: returns the reply and updates the ways
  function automatic btc_out_t cache_access(input btc_in_t w);
    btc_out_t    res;
    int unsigned set_idx;
    int unsigned base;
    int unsigned victim;
    bit          done;
    res = '0;
    done = 1'b0;
    set_idx = 32'((w.block_addr >> SET_LSB) & 64'(NUM_SETS - 1));
    base = set_idx * NUM_WAYS;
    case (w.mode)
      MODE_LOOKUP: begin
        for (int k = 0; k < NUM_WAYS; k++) begin
          if (!done && shadow_tags[base+k] == w.block_addr && shadow_vals[base+k] != '0) begin
            res.hit = 1'b1;
            res.code_out = shadow_vals[base+k];
            res.way_index = 2'(k);
            done = 1'b1;
          end
        end
      end
      MODE_INSERT: begin
        for (int k = 0; k < NUM_WAYS; k++) begin
          if (!done && shadow_tags[base+k] == w.block_addr) begin
            shadow_vals[base+k] = w.code_value;
            res.way_index = 2'(k);
            res.insert_kind = KIND_UPDATE;
            done = 1'b1;
          end
        end
        for (int k = 0; k < NUM_WAYS; k++) begin
          if (!done && shadow_vals[base+k] == '0) begin
            shadow_tags[base+k] = w.block_addr;
            shadow_vals[base+k] = w.code_value;
            res.way_index = 2'(k);
            res.insert_kind = KIND_FILL;
            done = 1'b1;
          end
        end
        if (!done) begin
          victim = 32'((w.block_addr >> VICTIM_LSB) & 64'(NUM_WAYS - 1));
          shadow_tags[base+victim] = w.block_addr;
          shadow_vals[base+victim] = w.code_value;
          res.way_index = 2'(victim);
          res.insert_kind = KIND_EVICT;
        end
      end
      MODE_CLEAR: wipe_shadow();
      default: ;
    endcase
    return res;
  endfunction

  function automatic btc_out_t mk_result(input logic hit, input logic [63:0] code,
                                         input logic [1:0] way, input logic [1:0] kind);
    btc_out_t r;
    r.hit = hit;
    r.code_out = code;
    r.way_index = way;
    r.insert_kind = kind;
    return r;
  endfunction

  function automatic void add_row(input logic [1:0] mode, input logic [63:0] addr,
                                  input logic [63:0] val, input logic fixed,
                                  input btc_out_t res);
    stim_row_t row;
    row.word.mode = mode;
    row.word.block_addr = addr;
    row.word.code_value = val;
    row.fixed = fixed;
    row.result = res;
    directed_rows.push_back(row);
  endfunction

  function automatic logic [63:0] set5_tag(input int k);
    return SET5_BASE | (64'(k) << 20);
  endfunction

  // a few crowded sets so that hits, updates and evictions are common
  function automatic void refill_pool();
    logic [SET_W-1:0] set_bits;
    logic [63:0]      addr;
    addr_pool.delete();
    addr_pool.push_back('0);
    for (int s = 0; s < 3; s++) begin
      set_bits = SET_W'($urandom);
      for (int t = 0; t < 6; t++) begin
        addr = {$urandom, $urandom};
        addr[SET_LSB +: SET_W] = set_bits;
        addr_pool.push_back(addr);
      end
    end
  endfunction

  function automatic btc_in_t random_word();
    btc_in_t     w;
    int unsigned r;
    r = $urandom_range(0, 999);
    if (r < 2) w.mode = MODE_CLEAR;
    else if (r < 30) w.mode = MODE_UNUSED;
    else if (r < 520) w.mode = MODE_LOOKUP;
    else w.mode = MODE_INSERT;
    if ($urandom_range(0, 99) < 85)
      w.block_addr = addr_pool[$urandom_range(0, addr_pool.size() - 1)];
    else w.block_addr = {$urandom, $urandom};
    r = $urandom_range(0, 19);
    if (r < 2) w.code_value = '0;
    else if (r == 2) w.code_value = ALL_ONES;
    else w.code_value = {$urandom, $urandom};
    return w;
  endfunction

  task automatic drive_word(input btc_in_t w, input logic fixed, input btc_out_t fixed_res);
    btc_out_t predicted;
    in_valid <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = cache_access(w);
    cache_replies_q.push_back(fixed ? fixed_res : predicted);
  endtask

  task automatic wait_for_replies();
    in_valid <= 1'b0;
    while (cache_replies_q.size() != 0) @(posedge clk);
  endtask

  function automatic void check_field(input string field, input logic [63:0] want,
                                      input logic [63:0] got);
    if (want !== got) begin
      mismatch_count++;
      if (mismatch_count <= 40)
        $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (cache_replies_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 40)
          $display("%0t: unexpected word, expected none, got %h", $time, out_data);
      end else begin
        reply_want = cache_replies_q.pop_front();
        check_field("hit", 64'(reply_want.hit), 64'(out_data.hit));
        check_field("code_out", reply_want.code_out, out_data.code_out);
        check_field("way_index", 64'(reply_want.way_index), 64'(out_data.way_index));
        check_field("insert_kind", 64'(reply_want.insert_kind), 64'(out_data.insert_kind));
      end
    end
    stall_cycle <= stall_cycle + 1;
    case ((stall_cycle >> 8) % 4)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 1) == 0);
      2: out_stall <= ($urandom_range(0, 7) < 6);
      default: out_stall <= (stall_cycle % 3 == 0);
    endcase
  end

  initial begin : sender
    btc_in_t w;
    int      counted;
    int      burst_left;
    int      gap;
    bit      calm;
    wipe_shadow();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    add_row(MODE_LOOKUP, '0, '0, 1'b1, '0);
    add_row(MODE_LOOKUP, ALL_ONES, ALL_ONES, 1'b1, '0);
    add_row(MODE_INSERT, ALL_ONES, ALL_ONES, 1'b1, mk_result(1'b0, '0, 2'd0, KIND_FILL));
    add_row(MODE_LOOKUP, ALL_ONES, '0, 1'b1, mk_result(1'b1, ALL_ONES, 2'd0, KIND_NONE));
    add_row(MODE_UNUSED, ALL_ONES, ALL_ONES, 1'b1, '0);
    add_row(MODE_LOOKUP, ALL_ONES, '0, 1'b0, '0);
    // address zero matches the zeroed tag of an empty way
    add_row(MODE_INSERT, '0, 64'h1234, 1'b0, '0);
    add_row(MODE_LOOKUP, '0, '0, 1'b0, '0);
    add_row(MODE_INSERT, '0, '0, 1'b0, '0);
    add_row(MODE_LOOKUP, '0, '0, 1'b0, '0);
    for (int k = 1; k <= 5; k++)
      add_row(MODE_INSERT, set5_tag(k), 64'h1111 * k, 1'b0, '0);
    add_row(MODE_LOOKUP, set5_tag(5), '0, 1'b0, '0);
    add_row(MODE_LOOKUP, set5_tag(2), '0, 1'b0, '0);
    add_row(MODE_INSERT, set5_tag(3), '0, 1'b0, '0);
    add_row(MODE_LOOKUP, set5_tag(3), '0, 1'b0, '0);
    add_row(MODE_INSERT, set5_tag(6) | 64'h3, ALL_ONES, 1'b0, '0);
    add_row(MODE_LOOKUP, set5_tag(6) | 64'h3, '0, 1'b0, '0);
    add_row(MODE_CLEAR, ALL_ONES, ALL_ONES, 1'b1, '0);
    add_row(MODE_LOOKUP, ALL_ONES, '0, 1'b1, '0);
    add_row(MODE_INSERT, ALL_ONES, 64'h1, 1'b1, mk_result(1'b0, '0, 2'd0, KIND_FILL));

    foreach (directed_rows[i])
      drive_word(directed_rows[i].word, directed_rows[i].fixed, directed_rows[i].result);
    wait_for_replies();

    for (int phase = 0; phase < PHASES; phase++) begin
      refill_pool();
      calm = (phase == 2);
      counted = 0;
      burst_left = 0;
      while (counted < WORDS_PER_PHASE) begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 16);
          gap = calm ? 0 : $urandom_range(0, 6);
          if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
          end
        end
        burst_left--;
        w = random_word();
        if (w.mode != MODE_UNUSED) counted++;
        drive_word(w, 1'b0, '0);
      end
      wait_for_replies();
    end

    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin : watchdog
    #5ms;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

[sim.f]
sv/btc_pkg.sv
sv/btc_ram.sv
sv/btc_way_sel.sv
sv/block_translation_cache_unit.sv
sv/btc_checker.sv
bench/block_translation_cache_unit_tb.sv
